### sv/tbps_pkg.sv
package tbps_pkg;

   // Field widths fixed by the interface
   localparam int ID_W     = 16;
   localparam int DEMAND_W = 10;
   localparam int LEVEL_W  = 10;
   localparam int DEPTH_W  = 10;
   localparam int COUNT_W  = 32;
   localparam int KIND_W   = 3;

   // Defaults for the top-level parameters
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int TOKEN_BITS_DEF  = 10;

   // Bucket depth after reset
   localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(10);

   // Result codes
   typedef enum logic [KIND_W-1:0] {
      EV_TOKEN_ADDED   = 3'd0,
      EV_TOKEN_DROPPED = 3'd1,
      EV_RELEASED      = 3'd2,
      EV_QUEUED        = 3'd3,
      EV_REJECTED      = 3'd4
   } event_kind_type;

   // Command classes handed from front to back
   typedef enum logic {
      CMD_TICK    = 1'b0,
      CMD_ARRIVAL = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [ID_W-1:0]     packet_id;
      logic [DEMAND_W-1:0] packet_tokens;
   } cmd_type;

endpackage

### sv/tbps_if.sv
// Input channel: one word is a tick or a packet arrival
interface tbps_req_if;
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic [tbps_pkg::ID_W-1:0]     packet_id;
   logic [tbps_pkg::DEMAND_W-1:0] packet_tokens;

   modport source (output valid, func, packet_id, packet_tokens, input ready);
   modport sink   (input valid, func, packet_id, packet_tokens, output ready);
endinterface

// Result channel: one word per shaper event
interface tbps_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tbps_pkg::KIND_W-1:0]  event_kind;
   logic [tbps_pkg::ID_W-1:0]    out_packet_id;
   logic [tbps_pkg::LEVEL_W-1:0] bucket_level;
   logic [tbps_pkg::COUNT_W-1:0] token_number;
   logic [tbps_pkg::COUNT_W-1:0] dropped_total;
   logic                         last;

   modport source (output valid, event_kind, out_packet_id, bucket_level, token_number,
                   dropped_total, last, input ready);
   modport sink   (input valid, event_kind, out_packet_id, bucket_level, token_number,
                   dropped_total, last, output ready);
endinterface

### sv/tbps_front.sv
module tbps_front (
   input  logic              clock,
   input  logic              reset,
   tbps_req_if.sink          req_chan,
   output logic              cmd_valid,
   output tbps_pkg::cmd_type cmd,
   input  logic              cmd_pop
);

   tbps_pkg::cmd_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;
   tbps_pkg::cmd_type classified;

   // Classify the incoming word
   always_comb begin
      classified.kind          = req_chan.func ? tbps_pkg::CMD_ARRIVAL : tbps_pkg::CMD_TICK;
      classified.packet_id     = req_chan.packet_id;
      classified.packet_tokens = req_chan.packet_tokens;
   end

   assign req_chan.ready = (count_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign cmd_valid      = (count_ff != 2'd0);
   assign cmd            = slot_ff[rd_ptr_ff];

   // Advance queue pointers
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold classified words
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

### sv/tbps_back.sv
module tbps_back #(
   parameter int QUEUE_DEPTH = tbps_pkg::QUEUE_DEPTH_DEF,
   parameter int TOKEN_BITS  = tbps_pkg::TOKEN_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [tbps_pkg::DEPTH_W-1:0]   csr_write_data,
   input  logic                           cmd_valid,
   input  tbps_pkg::cmd_type              cmd,
   output logic                           cmd_pop,
   tbps_rsp_if.source                     rsp_chan
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W = (TOKEN_BITS > tbps_pkg::DEMAND_W) ? TOKEN_BITS
                                                             : tbps_pkg::DEMAND_W;
   localparam int ID_W  = tbps_pkg::ID_W;
   localparam int DEM_W = tbps_pkg::DEMAND_W;
   localparam int CNT_W = tbps_pkg::COUNT_W;

   typedef enum logic {
      ST_IDLE,
      ST_EVAL
   } state_type;

   state_type                      state_ff, state_in;
   logic [TOKEN_BITS-1:0]          level_ff, level_in;
   logic [PTR_W-1:0]               head_ff, head_in;
   logic [PTR_W-1:0]               tail_ff, tail_in;
   logic [OCC_W-1:0]               occ_ff, occ_in;
   logic [CNT_W-1:0]               tick_ff, tick_in;
   logic [CNT_W-1:0]               drop_ff, drop_in;
   logic [tbps_pkg::DEPTH_W-1:0]   depth_ff, depth_in;
   tbps_pkg::event_kind_type       pend_kind_ff, pend_kind_in;
   logic [ID_W-1:0]                pend_id_ff, pend_id_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   tbps_pkg::event_kind_type       out_kind_ff, out_kind_in;
   logic [ID_W-1:0]                out_id_ff, out_id_in;
   logic [tbps_pkg::LEVEL_W-1:0]   out_level_ff, out_level_in;
   logic [CNT_W-1:0]               out_tick_ff, out_tick_in;
   logic [CNT_W-1:0]               out_drop_ff, out_drop_in;
   logic                           out_last_ff, out_last_in;

   // Packet queue storage and its registered read port
   logic [ID_W-1:0]                ids_mem [QUEUE_DEPTH];
   logic [DEM_W-1:0]               dem_mem [QUEUE_DEPTH];
   logic [ID_W-1:0]                rd_id_ff;
   logic [DEM_W-1:0]               rd_dem_ff;
   logic [PTR_W-1:0]               rd_addr;

   logic                           out_free;
   logic                           load;
   logic                           mem_write;
   logic                           queue_full;
   logic                           head_fits;
   logic [CMP_W-1:0]               level_ext;
   logic [CMP_W-1:0]               dem_ext;
   logic [CMP_W-1:0]               depth_ext;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      next_slot = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign level_ext  = CMP_W'(level_ff);
   assign dem_ext    = CMP_W'(rd_dem_ff);
   assign depth_ext  = CMP_W'(depth_ff);
   assign queue_full = (occ_ff == OCC_W'(QUEUE_DEPTH));
   assign head_fits  = (occ_ff != '0) && (dem_ext <= level_ext);
   assign cmd_pop    = (state_ff == ST_IDLE) && cmd_valid && out_free;
   assign mem_write  = cmd_pop && (cmd.kind == tbps_pkg::CMD_ARRIVAL) && !queue_full;

   // Read ahead at the next head while a release leaves
   assign rd_addr = ((state_ff == ST_EVAL) && out_free && head_fits) ? next_slot(head_ff)
                                                                      : head_ff;

   // Sequence ticks, arrivals and the release drain
   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      occ_in       = occ_ff;
      tick_in      = tick_ff;
      drop_in      = drop_ff;
      depth_in     = csr_write_enable ? csr_write_data : depth_ff;
      pend_kind_in = pend_kind_ff;
      pend_id_in   = pend_id_ff;
      load         = 1'b0;
      out_kind_in  = out_kind_ff;
      out_id_in    = out_id_ff;
      out_level_in = out_level_ff;
      out_tick_in  = out_tick_ff;
      out_drop_in  = out_drop_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_pop) begin
               if (cmd.kind == tbps_pkg::CMD_TICK) begin
                  tick_in    = tick_ff + 1'b1;
                  pend_id_in = '0;
                  if (level_ext < depth_ext) begin
                     level_in     = level_ff + 1'b1;
                     pend_kind_in = tbps_pkg::EV_TOKEN_ADDED;
                  end else begin
                     drop_in      = drop_ff + 1'b1;
                     pend_kind_in = tbps_pkg::EV_TOKEN_DROPPED;
                  end
                  state_in = ST_EVAL;
               end else begin
                  load         = 1'b1;
                  out_id_in    = cmd.packet_id;
                  out_level_in = tbps_pkg::LEVEL_W'(level_ext);
                  out_tick_in  = tick_ff;
                  out_drop_in  = drop_ff;
                  out_last_in  = 1'b1;
                  if (queue_full) begin
                     out_kind_in = tbps_pkg::EV_REJECTED;
                  end else begin
                     out_kind_in = tbps_pkg::EV_QUEUED;
                     tail_in     = next_slot(tail_ff);
                     occ_in      = occ_ff + 1'b1;
                  end
               end
            end
         end
         ST_EVAL: begin
            // Emit the pending word once it is known whether the head follows
            if (out_free) begin
               load         = 1'b1;
               out_kind_in  = pend_kind_ff;
               out_id_in    = pend_id_ff;
               out_level_in = tbps_pkg::LEVEL_W'(level_ext);
               out_tick_in  = tick_ff;
               out_drop_in  = drop_ff;
               out_last_in  = !head_fits;
               if (head_fits) begin
                  level_in     = TOKEN_BITS'(level_ext - dem_ext);
                  pend_kind_in = tbps_pkg::EV_RELEASED;
                  pend_id_in   = rd_id_ff;
                  head_in      = next_slot(head_ff);
                  occ_in       = occ_ff - 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Hold control state and the output word valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         tick_ff      <= '0;
         drop_ff      <= '0;
         depth_ff     <= tbps_pkg::DEPTH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         tick_ff      <= tick_in;
         drop_ff      <= drop_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_kind_ff <= pend_kind_in;
      pend_id_ff   <= pend_id_in;
      out_kind_ff  <= out_kind_in;
      out_id_ff    <= out_id_in;
      out_level_ff <= out_level_in;
      out_tick_ff  <= out_tick_in;
      out_drop_ff  <= out_drop_in;
      out_last_ff  <= out_last_in;
   end

   // Write at the tail, read at the head
   always_ff @(posedge clock) begin
      if (mem_write) begin
         ids_mem[tail_ff] <= cmd.packet_id;
         dem_mem[tail_ff] <= cmd.packet_tokens;
      end
      rd_id_ff  <= ids_mem[rd_addr];
      rd_dem_ff <= dem_mem[rd_addr];
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.event_kind    = out_kind_ff;
   assign rsp_chan.out_packet_id = out_id_ff;
   assign rsp_chan.bucket_level  = out_level_ff;
   assign rsp_chan.token_number  = out_tick_ff;
   assign rsp_chan.dropped_total = out_drop_ff;
   assign rsp_chan.last          = out_last_ff;

endmodule

### sv/token_bucket_packet_shaper.sv
// Token bucket shaper with a packet queue behind it.
// req_chan takes words with func 0 (token tick) or func 1 (packet arrival
// with packet_id and packet_tokens). rsp_chan gives one word per event:
// token added or dropped, packet released, queued or rejected when the queue
// is full; last marks the final word of each request.
// csr_write_enable / csr_write_data set the bucket depth (10 after reset);
// write it only while no request is in flight.
// A two-word command queue takes requests while the executing side works or
// the receiver stalls; requests are refused only when it is full.
// An arrival's word is loaded into the output register when it is taken; a tick
// goes through the pending register and the evaluate state, which then loads
// each released packet in turn, paced by the single read port of the packet
// store and the one output register; no new command is taken until it ends.
// Reset empties the bucket, the packet queue and the counters.
// A stalled receiver holds the output word and halts the execution side.
module token_bucket_packet_shaper #(
   parameter int QUEUE_DEPTH = tbps_pkg::QUEUE_DEPTH_DEF,
   parameter int TOKEN_BITS  = tbps_pkg::TOKEN_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   tbps_req_if.sink                     req_chan,
   tbps_rsp_if.source                   rsp_chan,
   input  logic                         csr_write_enable,
   input  logic [tbps_pkg::DEPTH_W-1:0] csr_write_data
);

   logic              cmd_valid;
   logic              cmd_pop;
   tbps_pkg::cmd_type cmd;

   tbps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   tbps_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TOKEN_BITS  (TOKEN_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .rsp_chan         (rsp_chan)
   );

`ifndef ASSERT_OFF
   // Take a command only when the front holds one
   a_pop_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command taken from an empty front queue");

   // An accepted word is visible to the back on the next cycle
   a_accept_reaches_back: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> cmd_valid)
      else $error("accepted word missing from the command queue");

   // Arrival outcomes always close their request
   a_arrival_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.event_kind == tbps_pkg::EV_QUEUED ||
                          rsp_chan.event_kind == tbps_pkg::EV_REJECTED))
      |-> rsp_chan.last)
      else $error("arrival result without last");

   // Token events carry no packet id
   a_token_no_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.event_kind == tbps_pkg::EV_TOKEN_ADDED ||
                          rsp_chan.event_kind == tbps_pkg::EV_TOKEN_DROPPED))
      |-> (rsp_chan.out_packet_id == '0))
      else $error("token event with a packet id");
`endif

endmodule
